FILE: design/vmn_pkg.sv
// Package for the virtio-mmio net register block: offsets, codes, helpers.
// No dependencies.
package vmn_pkg;

    localparam int unsigned DefQueueCount    = 2;
    localparam int unsigned DefMaxRing       = 256;
    localparam logic [11:0] ConfigBase       = 12'h100;

    localparam logic [11:0] OfsMagic        = 12'h000;
    localparam logic [11:0] OfsVersion      = 12'h004;
    localparam logic [11:0] OfsDeviceId     = 12'h008;
    localparam logic [11:0] OfsVendorId     = 12'h00C;
    localparam logic [11:0] OfsDevFeat      = 12'h010;
    localparam logic [11:0] OfsDevFeatSel   = 12'h014;
    localparam logic [11:0] OfsDrvFeat      = 12'h020;
    localparam logic [11:0] OfsDrvFeatSel   = 12'h024;
    localparam logic [11:0] OfsPageSize     = 12'h028;
    localparam logic [11:0] OfsQueueSel     = 12'h030;
    localparam logic [11:0] OfsQueueNumMax  = 12'h034;
    localparam logic [11:0] OfsQueueNum     = 12'h038;
    localparam logic [11:0] OfsQueueAlign   = 12'h03C;
    localparam logic [11:0] OfsQueuePfn     = 12'h040;
    localparam logic [11:0] OfsQueueNotify  = 12'h050;
    localparam logic [11:0] OfsIrqStatus    = 12'h060;
    localparam logic [11:0] OfsIrqAck       = 12'h064;
    localparam logic [11:0] OfsStatus       = 12'h070;

    localparam logic [31:0] MagicWord     = 32'h7472_6976;
    localparam logic [31:0] LegacyVersion = 32'd1;
    localparam logic [31:0] NetDeviceId   = 32'd1;
    localparam logic [31:0] FeatMask      = 32'h0001_0020;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_DONE  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_UNSUP = 2'd1,
        FAULT_RO    = 2'd2
    } t_fault;

    typedef enum logic [1:0] {
        CFG_MAC    = 2'd0,
        CFG_LINK   = 2'd1,
        CFG_VENDOR = 2'd2
    } t_cfg_idx;

    localparam logic [1:0] SizeWord = 2'd2;

    function automatic logic is_pow2(input logic [31:0] v);
        return (v != 32'd0) && ((v & (v - 32'd1)) == 32'd0);
    endfunction

endpackage

FILE: design/vmn_req_if.sv
// Request channel: register access or completion beat.
// Depends on nothing.
interface vmn_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] reg_offset;
    logic [1:0]  access_size;
    logic [63:0] write_data;

    modport source (output valid, mode, reg_offset, access_size, write_data, input ready);
    modport sink   (input valid, mode, reg_offset, access_size, write_data, output ready);
endinterface

FILE: design/vmn_rsp_if.sv
// Response channel: one result beat per request beat.
// Depends on nothing.
interface vmn_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  fault;
    logic [63:0] read_data;
    logic        irq_pending;
    logic        notify_accepted;
    logic        tx_notify_pending;
    logic        rx_notify_pending;
    logic        sel_queue_ready;
    logic [63:0] desc_table_addr;
    logic [63:0] avail_ring_addr;
    logic [63:0] used_ring_addr;

    modport source (output valid, fault, read_data, irq_pending, notify_accepted,
                    tx_notify_pending, rx_notify_pending, sel_queue_ready,
                    desc_table_addr, avail_ring_addr, used_ring_addr, input ready);
    modport sink   (input valid, fault, read_data, irq_pending, notify_accepted,
                    tx_notify_pending, rx_notify_pending, sel_queue_ready,
                    desc_table_addr, avail_ring_addr, used_ring_addr, output ready);
endinterface

FILE: design/vmn_ring_calc.sv
// Ring address computation for the selected queue.
// Depends on nothing; page size is a power of two when i_ok is set.
module vmn_ring_calc (
    input  logic        i_ok,
    input  logic [31:0] i_page_size,
    input  logic [31:0] i_pfn,
    input  logic [15:0] i_size,
    input  logic [31:0] i_align,
    output logic [63:0] o_desc,
    output logic [63:0] o_avail,
    output logic [63:0] o_used
);
    logic [4:0]  sh;
    logic [63:0] desc;
    logic [63:0] avail;
    logic [63:0] amask;

    // page size is one-hot here, so OR of set positions is its log2
    always_comb begin
        sh = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_page_size[i]) sh = sh | 5'(i);
        end
    end

    assign desc  = {32'd0, i_pfn} << sh;
    assign avail = desc + {44'd0, i_size, 4'd0};
    assign amask = {32'd0, i_align} - 64'd1;

    assign o_desc  = i_ok ? desc : 64'd0;
    assign o_avail = i_ok ? avail : 64'd0;
    assign o_used  = i_ok ? ((avail + 64'd4 + {47'd0, i_size, 1'b0} + amask) & ~amask)
                          : 64'd0;
endmodule

FILE: design/virtio_mmio_net_register_block.sv
// Legacy virtio-mmio net register file, top level. Uses vmn_pkg, vmn_req_if, vmn_rsp_if,
// vmn_ring_calc. The response beat is registered and valid in the cycle after acceptance.
// Throughput: one beat per cycle unless stalled; state updates at accept and the result
// register holds fault/read data while ring addresses are derived from live state.
// Reset (i_rst_n low, synchronous): all state cleared, link status 1, no response.
module virtio_mmio_net_register_block
    import vmn_pkg::*;
#(
    parameter int unsigned QUEUE_COUNT      = DefQueueCount,
    parameter int unsigned MAX_RING_ENTRIES = DefMaxRing
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    vmn_req_if.sink     i_req,
    vmn_rsp_if.source   o_rsp
);
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam logic [31:0] MaxRing = 32'(MAX_RING_ENTRIES);
    localparam logic [31:0] QCount  = 32'(QUEUE_COUNT);

    // config registers
    logic [47:0] r_mac;
    logic [15:0] r_link;
    logic [31:0] r_vendor;

    // device state
    logic [31:0] r_dev_fsel, n_dev_fsel;
    logic [31:0] r_drv_fsel, n_drv_fsel;
    logic [31:0] r_drv_feat, n_drv_feat;
    logic [31:0] r_page, n_page;
    logic [31:0] r_qidx, n_qidx;
    logic [7:0]  r_irq, n_irq;
    logic [7:0]  r_status, n_status;
    logic [15:0] r_q_size  [QUEUE_COUNT];
    logic [15:0] n_q_size  [QUEUE_COUNT];
    logic [31:0] r_q_align [QUEUE_COUNT];
    logic [31:0] n_q_align [QUEUE_COUNT];
    logic [31:0] r_q_pfn   [QUEUE_COUNT];
    logic [31:0] n_q_pfn   [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0] r_notify, n_notify;

    // result register
    logic        r_valid;
    logic [1:0]  r_fault, n_fault;
    logic [63:0] r_rdata, n_rdata;
    logic        r_acc, n_acc;

    logic accept;
    logic [QUEUE_COUNT-1:0] q_ok;
    logic        sel;
    logic [QW-1:0] q;
    logic [31:0] w;
    logic [63:0] img;
    logic [11:0] rel;
    logic        aligned_word;

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    // per-queue readiness on current state (used by notify and the ring calculation)
    always_comb begin
        for (int i = 0; i < QUEUE_COUNT; i++) begin
            q_ok[i] = is_pow2(r_page) && (r_q_pfn[i] != 32'd0) &&
                      (32'(r_q_size[i]) <= MaxRing) && is_pow2(32'(r_q_size[i])) &&
                      is_pow2(r_q_align[i]);
        end
    end

    assign sel = r_qidx < QCount;
    assign q   = sel ? r_qidx[QW-1:0] : '0;
    assign w   = i_req.write_data[31:0];
    assign img = {r_link, r_mac};
    assign rel = i_req.reg_offset - ConfigBase;
    assign aligned_word = (i_req.access_size == SizeWord) && (i_req.reg_offset[1:0] == 2'b00);

    always_comb begin
        n_dev_fsel = r_dev_fsel;
        n_drv_fsel = r_drv_fsel;
        n_drv_feat = r_drv_feat;
        n_page     = r_page;
        n_qidx     = r_qidx;
        n_irq      = r_irq;
        n_status   = r_status;
        n_notify   = r_notify;
        for (int i = 0; i < QUEUE_COUNT; i++) begin
            n_q_size[i]  = r_q_size[i];
            n_q_align[i] = r_q_align[i];
            n_q_pfn[i]   = r_q_pfn[i];
        end
        n_fault = FAULT_NONE;
        n_rdata = 64'd0;
        n_acc   = 1'b0;

        case (t_mode'(i_req.mode))
            MODE_READ: begin
                if (i_req.reg_offset >= ConfigBase) begin
                    // little-endian byte gather; bytes past eight read zero
                    for (int i = 0; i < 8; i++) begin
                        if ((i < (1 << i_req.access_size)) && (rel < 12'(8 - i))) begin
                            n_rdata[i*8 +: 8] = img[(rel[2:0] + 3'(i)) * 8 +: 8];
                        end
                    end
                end else if (!aligned_word) begin
                    n_fault = FAULT_UNSUP;
                end else begin
                    case (i_req.reg_offset)
                        OfsMagic:       n_rdata = {32'd0, MagicWord};
                        OfsVersion:     n_rdata = {32'd0, LegacyVersion};
                        OfsDeviceId:    n_rdata = {32'd0, NetDeviceId};
                        OfsVendorId:    n_rdata = {32'd0, r_vendor};
                        OfsDevFeat:     n_rdata = (r_dev_fsel == 32'd0) ? {32'd0, FeatMask} : 64'd0;
                        OfsQueueNumMax: n_rdata = sel ? {32'd0, MaxRing} : 64'd0;
                        OfsQueueNum:    n_rdata = sel ? {48'd0, r_q_size[q]} : 64'd0;
                        OfsQueueAlign:  n_rdata = sel ? {32'd0, r_q_align[q]} : 64'd0;
                        OfsQueuePfn:    n_rdata = sel ? {32'd0, r_q_pfn[q]} : 64'd0;
                        OfsIrqStatus:   n_rdata = {56'd0, r_irq};
                        OfsStatus:      n_rdata = {56'd0, r_status};
                        default:        n_rdata = 64'd0;
                    endcase
                end
            end
            MODE_WRITE: begin
                if (i_req.reg_offset >= ConfigBase) begin
                    n_fault = FAULT_RO;
                end else if (!aligned_word) begin
                    n_fault = FAULT_UNSUP;
                end else begin
                    case (i_req.reg_offset)
                        OfsDevFeatSel: n_dev_fsel = w;
                        OfsDrvFeat:    if (r_drv_fsel == 32'd0) n_drv_feat = w & FeatMask;
                        OfsDrvFeatSel: n_drv_fsel = w;
                        OfsPageSize:   n_page = w;
                        OfsQueueSel:   n_qidx = w;
                        OfsQueueNum:   if (sel) n_q_size[q] = w[15:0];
                        OfsQueueAlign: if (sel) n_q_align[q] = w;
                        OfsQueuePfn:   if (sel) n_q_pfn[q] = w;
                        OfsQueueNotify: begin
                            if ((w < QCount) && q_ok[w[QW-1:0]]) begin
                                n_notify[w[QW-1:0]] = 1'b1;
                                n_acc = 1'b1;
                            end
                        end
                        OfsIrqAck:     n_irq = r_irq & ~w[7:0];
                        OfsStatus: begin
                            if (w == 32'd0) begin
                                // status reset: all device state but page size
                                n_dev_fsel = 32'd0;
                                n_drv_fsel = 32'd0;
                                n_drv_feat = 32'd0;
                                n_qidx     = 32'd0;
                                n_irq      = 8'd0;
                                n_status   = 8'd0;
                                n_notify   = '0;
                                for (int i = 0; i < QUEUE_COUNT; i++) begin
                                    n_q_size[i]  = 16'd0;
                                    n_q_align[i] = 32'd0;
                                    n_q_pfn[i]   = 32'd0;
                                end
                            end else begin
                                n_status = w[7:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            MODE_DONE: n_irq = r_irq | 8'h01;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac      <= 48'd0;
            r_link     <= 16'd1;
            r_vendor   <= 32'd0;
            r_dev_fsel <= 32'd0;
            r_drv_fsel <= 32'd0;
            r_drv_feat <= 32'd0;
            r_page     <= 32'd0;
            r_qidx     <= 32'd0;
            r_irq      <= 8'd0;
            r_status   <= 8'd0;
            r_notify   <= '0;
            r_valid    <= 1'b0;
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                r_q_size[i]  <= 16'd0;
                r_q_align[i] <= 32'd0;
                r_q_pfn[i]   <= 32'd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAC:    r_mac    <= i_cfg_data;
                    CFG_LINK:   r_link   <= i_cfg_data[15:0];
                    CFG_VENDOR: r_vendor <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_dev_fsel <= n_dev_fsel;
                r_drv_fsel <= n_drv_fsel;
                r_drv_feat <= n_drv_feat;
                r_page     <= n_page;
                r_qidx     <= n_qidx;
                r_irq      <= n_irq;
                r_status   <= n_status;
                r_notify   <= n_notify;
                for (int i = 0; i < QUEUE_COUNT; i++) begin
                    r_q_size[i]  <= n_q_size[i];
                    r_q_align[i] <= n_q_align[i];
                    r_q_pfn[i]   <= n_q_pfn[i];
                end
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fault <= n_fault;
            r_rdata <= n_rdata;
            r_acc   <= n_acc;
        end
    end

    // drv features are stored for the driver side; not visible on the response
    vmn_ring_calc u_calc (
        .i_ok        (sel && q_ok[q]),
        .i_page_size (r_page),
        .i_pfn       (r_q_pfn[q]),
        .i_size      (r_q_size[q]),
        .i_align     (r_q_align[q]),
        .o_desc      (o_rsp.desc_table_addr),
        .o_avail     (o_rsp.avail_ring_addr),
        .o_used      (o_rsp.used_ring_addr)
    );

    assign o_rsp.valid             = r_valid;
    assign o_rsp.fault             = r_fault;
    assign o_rsp.read_data         = r_rdata;
    assign o_rsp.irq_pending       = r_irq[0];
    assign o_rsp.notify_accepted   = r_acc;
    assign o_rsp.rx_notify_pending = r_notify[0];
    assign o_rsp.sel_queue_ready   = sel && q_ok[q];

    generate
        if (QUEUE_COUNT > 1) begin : g_tx
            assign o_rsp.tx_notify_pending = r_notify[1];
        end else begin : g_no_tx
            assign o_rsp.tx_notify_pending = 1'b0;
        end
    endgenerate
endmodule
